// ===== rtl/core/npz_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npz_pkg
// Shared types and constants for the neutrino pz mass-constraint solver.
// ----------------------------------------------------------------------------
package npz_pkg;

  // Default momentum field width, 1/16 GeV units
  localparam int unsigned MOMENTUM_BITS_DEF = 18;

  // Multiplier digit width: one digit of the second operand per cell
  localparam int unsigned DIGIT_BITS = 8;

  // Configuration register widths and reset values
  localparam int unsigned BMS_BITS = 24;
  localparam int unsigned LMS_BITS = 16;
  localparam logic [BMS_BITS-1:0] BMS_RESET = 24'd1654825;
  localparam logic [LMS_BITS-1:0] LMS_RESET = 16'd0;

  // APB data and address widths
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = 3;

  // Register index (word address)
  typedef enum logic {
    REG_BOSON_MASS_SQ  = 1'b0,
    REG_LEPTON_MASS_SQ = 1'b1
  } npz_reg_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_REAL       = 2'd0,
    STATUS_NEG_DISC   = 2'd1,
    STATUS_DEGENERATE = 2'd2
  } npz_status_e;

endpackage
`default_nettype wire

// ===== rtl/core/npz_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npz_if
// Valid/ready stream interfaces for lepton requests and root results.
// ----------------------------------------------------------------------------
interface npz_in_if #(
  parameter int unsigned W = 18
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] lep_px;
  logic signed [W-1:0] lep_py;
  logic signed [W-1:0] lep_pz;
  logic        [W-2:0] lep_energy;
  logic signed [W-1:0] miss_px;
  logic signed [W-1:0] miss_py;

  modport source (output valid, lep_px, lep_py, lep_pz, lep_energy, miss_px, miss_py,
                  input ready);
  modport sink   (input valid, lep_px, lep_py, lep_pz, lep_energy, miss_px, miss_py,
                  output ready);
endinterface

interface npz_out_if import npz_pkg::*; #(
  parameter int unsigned W = 18
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] root_plus;
  logic signed [W-1:0] root_minus;
  npz_status_e         status;

  modport source (output valid, root_plus, root_minus, status, input ready);
  modport sink   (input valid, root_plus, root_minus, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/npz_dly.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npz_dly
// Enabled shift line that keeps side data aligned with the arithmetic cells.
// ----------------------------------------------------------------------------
module npz_dly #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  // shift on every pipeline advance
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule
`default_nettype wire

// ===== rtl/core/npz_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npz_mul
// Unsigned multiplier as a row of cells, one digit of b per cell.
// ----------------------------------------------------------------------------
module npz_mul import npz_pkg::*; #(
  parameter int unsigned A_BITS = 8,
  parameter int unsigned B_BITS = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [A_BITS-1:0]        a_i,
  input  wire logic [B_BITS-1:0]        b_i,
  output logic      [A_BITS+B_BITS-1:0] p_o
);

  localparam int unsigned Steps = (B_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned PadW  = Steps * DIGIT_BITS;
  localparam int unsigned ProdW = A_BITS + B_BITS;
  localparam int unsigned PartW = A_BITS + DIGIT_BITS;

  logic [A_BITS-1:0] a_in   [Steps];
  logic [PadW-1:0]   b_in   [Steps];
  logic [ProdW-1:0]  acc_in [Steps];
  logic [A_BITS-1:0] a_q    [Steps];
  logic [PadW-1:0]   b_q    [Steps];
  logic [ProdW-1:0]  acc_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_cell
    logic [PartW-1:0] part;

    if (k == 0) begin : g_first
      assign a_in[k]   = a_i;
      assign b_in[k]   = PadW'(b_i);
      assign acc_in[k] = '0;
    end else begin : g_next
      assign a_in[k]   = a_q[k-1];
      assign b_in[k]   = b_q[k-1];
      assign acc_in[k] = acc_q[k-1];
    end

    // partial product of this digit, added at its weight
    assign part = PartW'(a_in[k]) * PartW'(b_in[k][k*DIGIT_BITS +: DIGIT_BITS]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k]   <= a_in[k];
        b_q[k]   <= b_in[k];
        acc_q[k] <= acc_in[k] + (ProdW'(part) << (k * DIGIT_BITS));
      end
    end
  end

  assign p_o = acc_q[Steps-1];

endmodule
`default_nettype wire

// ===== rtl/core/npz_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npz_isqrt
// Integer square root, floor, as a row of cells settling one root bit each.
// ----------------------------------------------------------------------------
module npz_isqrt #(
  parameter int unsigned RAD_BITS = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [RAD_BITS-1:0]       rad_i,
  output logic      [(RAD_BITS+1)/2-1:0] root_o
);

  localparam int unsigned SW   = (RAD_BITS + 1) / 2;
  localparam int unsigned PadW = 2 * SW;
  localparam int unsigned RemW = SW + 2;

  logic [PadW-1:0] rad_in  [SW];
  logic [RemW-1:0] rem_in  [SW];
  logic [SW-1:0]   root_in [SW];
  logic [PadW-1:0] rad_q   [SW];
  logic [RemW-1:0] rem_q   [SW];
  logic [SW-1:0]   root_q  [SW];

  for (genvar k = 0; k < SW; k++) begin : g_cell
    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;
    logic            fits;

    if (k == 0) begin : g_first
      assign rad_in[k]  = PadW'(rad_i);
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
    end else begin : g_next
      assign rad_in[k]  = rad_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
    end

    // bring down the next pair of radicand bits, try root*4+1
    assign rem_sh = {rem_in[k][SW-1:0], rad_in[k][2*(SW-1-k) +: 2]};
    assign trial  = {root_in[k], 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in[k];
        rem_q[k]  <= fits ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[k][SW-2:0], fits};
      end
    end
  end

  assign root_o = root_q[SW-1];

endmodule
`default_nettype wire

// ===== rtl/core/npz_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npz_div
// Rounded, saturated N/(2Q): restoring division, one quotient bit per cell.
// ----------------------------------------------------------------------------
module npz_div #(
  parameter int unsigned W      = 18,
  parameter int unsigned N_BITS = 8,
  parameter int unsigned Q_BITS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [N_BITS-1:0] n_mag_i,
  input  wire logic              neg_i,
  input  wire logic [Q_BITS-1:0] q_mag_i,
  output logic signed [W-1:0]    root_o
);

  localparam int unsigned TopW = (N_BITS > Q_BITS ? N_BITS : Q_BITS) + 1;
  localparam int unsigned DenW = Q_BITS + 1;
  localparam int unsigned XW   = (TopW > DenW + W ? TopW : DenW + W) + 1;

  logic [XW-1:0]   top_x;
  logic [XW-1:0]   den_x;
  logic            ovf_d;

  logic [XW-1:0]   rem_q  [W+1];
  logic [DenW-1:0] den_q  [W+1];
  logic            neg_q  [W+1];
  logic            ovf_q  [W+1];
  logic [W-1:0]    quo_q  [W+1];

  logic [W-1:0]    lim;
  logic [W-1:0]    mag;

  // rounding: floor((|N| + |Q|) / (2|Q|)); quotient too large for W bits saturates
  assign top_x = XW'(n_mag_i) + XW'(q_mag_i);
  assign den_x = XW'({q_mag_i, 1'b0});
  assign ovf_d = top_x >= (den_x << W);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= top_x;
      den_q[0] <= {q_mag_i, 1'b0};
      neg_q[0] <= neg_i;
      ovf_q[0] <= ovf_d;
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_cell
    logic [XW-1:0] shd;
    logic          fits;

    assign shd  = XW'(den_q[k-1]) << (W - k);
    assign fits = rem_q[k-1] >= shd;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fits ? rem_q[k-1] - shd : rem_q[k-1];
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        quo_q[k] <= quo_q[k-1] | (W'(fits) << (W - k));
      end
    end
  end

  // saturate to the signed field range, then apply the sign
  assign lim    = neg_q[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign mag    = (ovf_q[W] || (quo_q[W] > lim)) ? lim : quo_q[W];
  assign root_o = neg_q[W] ? $signed(-mag) : $signed(mag);

endmodule
`default_nettype wire

// ===== rtl/core/neutrino_pz_mass_constraint.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// neutrino_pz_mass_constraint
// Neutrino pz candidates from the W-mass constraint quadratic, fully pipelined.
// ----------------------------------------------------------------------------
// Pipeline: a request passes the S1 and S2 registers, the digit-serial
//   multiplier rows, S3, the SW-cell square-root row, the W+1-stage divider
//   rows and the output register on its way to the result.
// Throughput: one request per cycle; the whole pipe stalls only while a
//   result is held at the output.
// Reset: clears the pipeline valid bits and loads the register reset values.
module neutrino_pz_mass_constraint import npz_pkg::*; #(
  parameter int unsigned MOMENTUM_BITS = MOMENTUM_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  npz_in_if.sink                        req_i,
  npz_out_if.source                     rsp_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  localparam int unsigned W    = MOMENTUM_BITS;
  localparam int unsigned W2   = 2 * W;
  localparam int unsigned EW   = 2 * W - 2;
  localparam int unsigned SqW  = 2 * W - 1;
  localparam int unsigned DotW = 2 * W + 1;
  localparam int unsigned AW   = (W2 > BMS_BITS ? W2 : BMS_BITS) + 2;
  localparam int unsigned AMW  = AW - 1;
  localparam int unsigned QMW  = W2 - 1;
  localparam int unsigned PtW  = W2;
  localparam int unsigned M1W  = 2 * AMW;
  localparam int unsigned RMW  = 2 * AMW + 1;
  localparam int unsigned DW   = RMW + EW;
  localparam int unsigned SW   = (DW + 1) / 2;
  localparam int unsigned BMW  = AMW + W;
  localparam int unsigned NMW  = (BMW > SW ? BMW : SW) + 1;
  localparam int unsigned L1   = (AMW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned L2   = (EW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned LD   = W + 1;
  localparam int unsigned LAT  = 3 + L1 + L2 + SW + LD;
  localparam int unsigned S3   = 2 + L1;
  localparam int unsigned SideW1 = EW + 3 + QMW;
  localparam int unsigned SideW2 = BMW + 2 + QMW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [BMS_BITS-1:0] bms_q;
  logic [LMS_BITS-1:0] lms_q;
  logic                cfg_wr;
  npz_reg_e            cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = npz_reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bms_q <= BMS_RESET;
      lms_q <= LMS_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BOSON_MASS_SQ:  bms_q <= pwdata[BMS_BITS-1:0];
        REG_LEPTON_MASS_SQ: lms_q <= pwdata[LMS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BOSON_MASS_SQ:  prdata = APB_DATA_BITS'(bms_q);
      REG_LEPTON_MASS_SQ: prdata = APB_DATA_BITS'(lms_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: everything advances unless a result is held
  logic           en;
  logic [LAT-1:0] v_q;
  logic           out_valid_q;

  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[LAT-2:0], req_i.valid};
      out_valid_q <= v_q[LAT-1];
    end
  end

  // ---------------------------------------------------------------------------
  // S1: narrow products
  logic signed [W2-1:0] pxx_s1_q, pyy_s1_q;
  logic        [EW-1:0] e2_s1_q;
  logic        [SqW-1:0] lz2_s1_q, mx2_s1_q, my2_s1_q;
  logic signed [W-1:0]  lz_s1_q;
  logic signed [W2-1:0] lz2_full, mx2_full, my2_full;

  assign lz2_full = W2'(req_i.lep_pz) * W2'(req_i.lep_pz);
  assign mx2_full = W2'(req_i.miss_px) * W2'(req_i.miss_px);
  assign my2_full = W2'(req_i.miss_py) * W2'(req_i.miss_py);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxx_s1_q <= W2'(req_i.miss_px) * W2'(req_i.lep_px);
      pyy_s1_q <= W2'(req_i.miss_py) * W2'(req_i.lep_py);
      e2_s1_q  <= EW'(req_i.lep_energy) * EW'(req_i.lep_energy);
      lz2_s1_q <= lz2_full[SqW-1:0];
      mx2_s1_q <= mx2_full[SqW-1:0];
      my2_s1_q <= my2_full[SqW-1:0];
      lz_s1_q  <= req_i.lep_pz;
    end
  end

  // ---------------------------------------------------------------------------
  // S2: a, Q and pt^2, split into sign and magnitude
  logic signed [DotW-1:0] dot_d;
  logic signed [AW-1:0]   a_d;
  logic signed [W2-1:0]   q_d;
  logic signed [AW-1:0]   a_abs;
  logic signed [W2-1:0]   q_abs;
  logic signed [W-1:0]    lz_abs;

  logic [AMW-1:0] a_mag_s2_q;
  logic           a_neg_s2_q;
  logic [QMW-1:0] q_mag_s2_q;
  logic           q_neg_s2_q, q_zero_s2_q;
  logic [PtW-1:0] pt2_s2_q;
  logic [W-1:0]   lz_mag_s2_q;
  logic           lz_neg_s2_q;
  logic [EW-1:0]  e2_s2_q;

  assign dot_d  = DotW'(pxx_s1_q) + DotW'(pyy_s1_q);
  assign a_d    = AW'($signed({1'b0, bms_q})) - AW'($signed({1'b0, lms_q}))
                + (AW'(dot_d) <<< 1);
  assign q_d    = W2'($signed({1'b0, e2_s1_q})) - W2'($signed({1'b0, lz2_s1_q}));
  assign a_abs  = a_d[AW-1] ? -a_d : a_d;
  assign q_abs  = q_d[W2-1] ? -q_d : q_d;
  assign lz_abs = lz_s1_q[W-1] ? -lz_s1_q : lz_s1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mag_s2_q  <= a_abs[AMW-1:0];
      a_neg_s2_q  <= a_d[AW-1];
      q_mag_s2_q  <= q_abs[QMW-1:0];
      q_neg_s2_q  <= q_d[W2-1];
      q_zero_s2_q <= (q_d == '0);
      pt2_s2_q    <= PtW'(mx2_s1_q) + PtW'(my2_s1_q);
      lz_mag_s2_q <= lz_abs;
      lz_neg_s2_q <= lz_s1_q[W-1];
      e2_s2_q     <= e2_s1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // M1: a^2, |Q|*pt^2 and |a*lz|
  logic [M1W-1:0]    a2_m1, qp_m1, base_m1;
  logic [SideW1-1:0] side1_d, side1_q;

  npz_mul #(.A_BITS(AMW), .B_BITS(AMW)) u_mul_a2 (
    .clk_i, .en_i(en), .a_i(a_mag_s2_q), .b_i(a_mag_s2_q), .p_o(a2_m1)
  );
  npz_mul #(.A_BITS(AMW), .B_BITS(AMW)) u_mul_qp (
    .clk_i, .en_i(en), .a_i(AMW'(q_mag_s2_q)), .b_i(AMW'(pt2_s2_q)), .p_o(qp_m1)
  );
  npz_mul #(.A_BITS(AMW), .B_BITS(AMW)) u_mul_base (
    .clk_i, .en_i(en), .a_i(a_mag_s2_q), .b_i(AMW'(lz_mag_s2_q)), .p_o(base_m1)
  );

  assign side1_d = {e2_s2_q, q_neg_s2_q, q_zero_s2_q, a_neg_s2_q ^ lz_neg_s2_q, q_mag_s2_q};

  npz_dly #(.WIDTH(SideW1), .DEPTH(L1)) u_dly_m1 (
    .clk_i, .en_i(en), .d_i(side1_d), .q_o(side1_q)
  );

  // ---------------------------------------------------------------------------
  // S3: R = a^2 - 4*Q*pt^2
  logic [EW-1:0]  e2_m1;
  logic           q_neg_m1, q_zero_m1, base_neg_m1;
  logic [QMW-1:0] q_mag_m1;
  logic [RMW-1:0] a2_x, qp4_x;
  logic           r_neg_d;

  assign {e2_m1, q_neg_m1, q_zero_m1, base_neg_m1, q_mag_m1} = side1_q;
  assign a2_x    = RMW'(a2_m1);
  assign qp4_x   = RMW'(qp_m1) << 2;
  assign r_neg_d = !q_neg_m1 && (qp4_x > a2_x);

  logic [RMW-1:0] r_mag_s3_q;
  logic           r_neg_s3_q;
  logic [EW-1:0]  e2_s3_q;
  logic [BMW-1:0] base_mag_s3_q;
  logic           base_neg_s3_q;
  logic [QMW-1:0] q_mag_s3_q;
  logic           q_neg_s3_q, q_zero_s3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_mag_s3_q    <= q_neg_m1 ? a2_x + qp4_x : (r_neg_d ? '0 : a2_x - qp4_x);
      r_neg_s3_q    <= r_neg_d;
      e2_s3_q       <= e2_m1;
      base_mag_s3_q <= base_m1[BMW-1:0];
      base_neg_s3_q <= base_neg_m1;
      q_mag_s3_q    <= q_mag_m1;
      q_neg_s3_q    <= q_neg_m1;
      q_zero_s3_q   <= q_zero_m1;
    end
  end

  // ---------------------------------------------------------------------------
  // M2 and square root: S = floor(sqrt(E^2 * R))
  logic [DW-1:0]     disc_m2;
  logic [SW-1:0]     s_root;
  logic [SideW2-1:0] side2_q;
  logic [1:0]        flags_q;

  npz_mul #(.A_BITS(RMW), .B_BITS(EW)) u_mul_disc (
    .clk_i, .en_i(en), .a_i(r_mag_s3_q), .b_i(e2_s3_q), .p_o(disc_m2)
  );

  npz_isqrt #(.RAD_BITS(DW)) u_isqrt (
    .clk_i, .en_i(en), .rad_i(disc_m2), .root_o(s_root)
  );

  npz_dly #(.WIDTH(SideW2), .DEPTH(L2 + SW)) u_dly_sq (
    .clk_i, .en_i(en),
    .d_i({base_mag_s3_q, base_neg_s3_q, q_neg_s3_q, q_mag_s3_q}),
    .q_o(side2_q)
  );

  npz_dly #(.WIDTH(2), .DEPTH(L2 + SW + LD)) u_dly_flags (
    .clk_i, .en_i(en), .d_i({q_zero_s3_q, r_neg_s3_q}), .q_o(flags_q)
  );

  // ---------------------------------------------------------------------------
  // Numerators N = a*lz +/- S, then the two divider rows
  logic [BMW-1:0]       base_mag_sq;
  logic                 base_neg_sq, q_neg_sq;
  logic [QMW-1:0]       q_mag_sq;
  logic signed [NMW:0]  base_s, s_x, np_s, nm_s, np_abs, nm_abs;
  logic signed [W-1:0]  root_p, root_m;

  assign {base_mag_sq, base_neg_sq, q_neg_sq, q_mag_sq} = side2_q;
  assign base_s = base_neg_sq ? -$signed((NMW+1)'(base_mag_sq))
                              :  $signed((NMW+1)'(base_mag_sq));
  assign s_x    = $signed((NMW+1)'(s_root));
  assign np_s   = base_s + s_x;
  assign nm_s   = base_s - s_x;
  assign np_abs = np_s[NMW] ? -np_s : np_s;
  assign nm_abs = nm_s[NMW] ? -nm_s : nm_s;

  npz_div #(.W(W), .N_BITS(NMW), .Q_BITS(QMW)) u_div_plus (
    .clk_i, .en_i(en), .n_mag_i(np_abs[NMW-1:0]), .neg_i(np_s[NMW] ^ q_neg_sq),
    .q_mag_i(q_mag_sq), .root_o(root_p)
  );
  npz_div #(.W(W), .N_BITS(NMW), .Q_BITS(QMW)) u_div_minus (
    .clk_i, .en_i(en), .n_mag_i(nm_abs[NMW-1:0]), .neg_i(nm_s[NMW] ^ q_neg_sq),
    .q_mag_i(q_mag_sq), .root_o(root_m)
  );

  // ---------------------------------------------------------------------------
  // Output register: degenerate and complex cases force zero roots
  logic signed [W-1:0] root_plus_q, root_minus_q;
  npz_status_e         status_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (flags_q[1]) begin
        root_plus_q  <= '0;
        root_minus_q <= '0;
        status_q     <= STATUS_DEGENERATE;
      end else if (flags_q[0]) begin
        root_plus_q  <= '0;
        root_minus_q <= '0;
        status_q     <= STATUS_NEG_DISC;
      end else begin
        root_plus_q  <= root_p;
        root_minus_q <= root_m;
        status_q     <= STATUS_REAL;
      end
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.root_plus  = root_plus_q;
  assign rsp_o.root_minus = root_minus_q;
  assign rsp_o.status     = status_q;

  // ---------------------------------------------------------------------------
  // Assertions

  // with Q negative R = a^2 + 4|Q|pt^2 can never go negative
  a_rneg_needs_qpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S3] |-> !(r_neg_s3_q && q_neg_s3_q))
    else $error("negative discriminant with negative Q");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == STATUS_DEGENERATE) |-> (root_plus_q == '0 && root_minus_q == '0))
    else $error("degenerate result with nonzero roots");

  a_negdisc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == STATUS_NEG_DISC) |-> (root_plus_q == '0 && root_minus_q == '0))
    else $error("negative discriminant with nonzero roots");

endmodule
`default_nettype wire
